>>> rtl/pdfx_pkg.sv
`default_nettype none

package pdfx_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_UD     = 8'h44;  // 'D'
  localparam logic [7:0] CH_LD     = 8'h64;  // 'd'
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_HIGH   = 8'h80;
  localparam logic [7:0] CH_FF     = 8'hff;

  // Configuration
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned GAP_W     = 16;
  localparam logic [GAP_W-1:0] GAP_RESET = 16'd100;
  localparam logic [0:0]  REG_GAP_THRESHOLD = 1'b0;

  // Integer part: five decimal digits cover the 16-bit threshold
  localparam int unsigned INT_DIGITS = 5;
  localparam int unsigned VAL_W      = 17;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_stream;
  } in_item_t;

  // Up to two result bytes caused by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } res_pair_t;

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    return ((b >= CH_SPACE) && (b <= CH_TILDE)) || ((b >= CH_HIGH) && (b != CH_FF));
  endfunction

endpackage

`default_nettype wire

>>> rtl/pdfx_if.sv
`default_nettype none

interface pdfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_stream;

  modport source (output valid, in_byte, first_of_stream, input ready);
  modport sink   (input valid, in_byte, first_of_stream, output ready);
endinterface

interface pdfx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

>>> rtl/pdfx_num_scan.sv
`default_nettype none

// Finds the number just before the trailing spaces of the window and
// compares it with the gap threshold. Mask arithmetic, no serial scan.
module pdfx_num_scan #(
  parameter int unsigned WINDOW_BYTES = 15
) (
  input  logic [WINDOW_BYTES-1:0][7:0] win,
  input  logic [WINDOW_BYTES-1:0]      dig,
  input  logic [WINDOW_BYTES-1:0]      dot,
  input  logic [WINDOW_BYTES-1:0]      sp,
  input  logic [WINDOW_BYTES-1:0]      nz,
  input  logic [pdfx_pkg::GAP_W-1:0]   gap_threshold,
  output logic                         exceed
);
  import pdfx_pkg::*;

  localparam int unsigned W = WINDOW_BYTES;
  localparam logic [W-1:0] BIT0 = W'(1);

  logic [W-1:0] sp_x, sp_rev, tail_rev, tail;
  logic [W-1:0] u, u_rev, blk_rev, blk, run;
  logic [W-1:0] dots, lsb1, int_m, rest, lsb2, frac_m;
  logic [W-1:0] e_oh, e_hi, lowmask;
  logic [3:0]   dg [INT_DIGITS];
  logic [VAL_W-1:0] val;
  logic any_dig, frac_nz, over5;

  always_comb begin
    // trailing spaces (oldest byte never counts)
    sp_x = sp & ~BIT0;
    for (int i = 0; i < W; i++) sp_rev[i] = sp_x[W-1-i];
    tail_rev = sp_rev & ~(sp_rev + BIT0);
    for (int i = 0; i < W; i++) tail[i] = tail_rev[W-1-i];

    // run of digits and dots right below the trailing spaces
    u = ((dig | dot) & ~BIT0) | tail;
    for (int i = 0; i < W; i++) u_rev[i] = u[W-1-i];
    blk_rev = u_rev & ~(u_rev + BIT0);
    for (int i = 0; i < W; i++) blk[i] = blk_rev[W-1-i];
    run = blk & ~tail;

    // integer part below the first dot, fraction up to the second dot
    dots   = dot & run;
    lsb1   = dots & (~dots + BIT0);
    int_m  = run & (lsb1 - BIT0);
    rest   = dots & ~lsb1;
    lsb2   = rest & (~rest + BIT0);
    frac_m = run & ~int_m & ~lsb1 & (lsb2 - BIT0);

    any_dig = (|int_m) || (|frac_m);
    frac_nz = |(frac_m & nz);

    // units digit of the integer part (its highest bit), and nonzero digits beyond five places
    e_oh    = int_m & ~(int_m >> 1);
    e_hi    = e_oh >> (INT_DIGITS - 1);
    lowmask = (|e_hi) ? (e_hi - BIT0) : '0;
    over5   = |(int_m & nz & lowmask);

    for (int t = 0; t < INT_DIGITS; t++) dg[t] = 4'd0;
    for (int t = 0; t < INT_DIGITS; t++) begin
      for (int i = t; i < W; i++) begin
        if (e_oh[i] && int_m[i-t]) dg[t] = dg[t] | win[i-t][3:0];
      end
    end

    val = VAL_W'(dg[0]) + VAL_W'(dg[1]) * VAL_W'(10) + VAL_W'(dg[2]) * VAL_W'(100)
        + VAL_W'(dg[3]) * VAL_W'(1000) + VAL_W'(dg[4]) * VAL_W'(10000);

    exceed = any_dig && (over5 || (val > VAL_W'(gap_threshold)) ||
                         ((val == VAL_W'(gap_threshold)) && frac_nz));
  end

endmodule

`default_nettype wire

>>> rtl/pdfx_res_buf.sv
`default_nettype none

// Two-slot result register. Shows b0 first; last marks the final byte.
module pdfx_res_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pdfx_pkg::res_pair_t res,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                free
);
  import pdfx_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] b0_r, b0_nxt, b1_r, b1_nxt;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign free      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_valid = (cnt_r != 2'd0);
  assign out_byte  = b0_r;
  assign out_last  = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    b0_nxt  = b0_r;
    b1_nxt  = b1_r;
    if (pop) begin
      if (cnt_r == 2'd2) begin
        cnt_nxt = 2'd1;
        b0_nxt  = b1_r;
      end else begin
        cnt_nxt = 2'd0;
      end
    end
    if (load) begin
      cnt_nxt = res.cnt;
      b0_nxt  = res.b0;
      b1_nxt  = res.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/pdfx_parse.sv
`default_nettype none

// Byte window, text-object/string/escape flags and the per-byte decisions.
module pdfx_parse #(
  parameter int unsigned WINDOW_BYTES = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  pdfx_pkg::in_item_t         item,
  input  logic [pdfx_pkg::GAP_W-1:0] gap_threshold,
  output pdfx_pkg::res_pair_t        res
);
  import pdfx_pkg::*;

  localparam int unsigned W = WINDOW_BYTES;

  logic [W-1:0][7:0] win_r, win_nxt;
  logic [W-1:0] dig_r, dig_nxt, dot_r, dot_nxt, sp_r, sp_nxt, nz_r, nz_nxt;
  logic tob_r, tob_nxt, str_r, str_nxt, esc_r, esc_nxt;
  logic first, tob_c, str_c, esc_c;
  logic tok_td, tok_et, tok_bt, exceed_raw;
  logic nl, gap_sp, txt;
  logic [7:0] c;

  function automatic logic tok_at(input logic [W-1:0][7:0] w, input logic [7:0] x,
                                  input logic [7:0] y);
    return (w[W-3] == x) && (w[W-2] == y) && is_sep(w[W-1]) && is_sep(w[W-4]);
  endfunction

  pdfx_num_scan #(.WINDOW_BYTES(W)) u_num_scan (
    .win           (win_r),
    .dig           (dig_r),
    .dot           (dot_r),
    .sp            (sp_r),
    .nz            (nz_r),
    .gap_threshold (gap_threshold),
    .exceed        (exceed_raw)
  );

  always_comb begin
    c     = item.in_byte;
    first = item.first_of_stream;
    // start of stream: flags cleared, window all spaces
    tob_c = tob_r & ~first;
    str_c = str_r & ~first;
    esc_c = esc_r & ~first;

    tok_td = !first && (tok_at(win_r, CH_T, CH_UD) || tok_at(win_r, CH_T, CH_LD));
    tok_et = !first && tok_at(win_r, CH_E, CH_T);
    // BT checked on the window after c is shifted in
    tok_bt = !first && (win_r[W-2] == CH_B) && (win_r[W-1] == CH_T) &&
             is_sep(c) && is_sep(win_r[W-3]);

    nl      = 1'b0;
    gap_sp  = 1'b0;
    txt     = 1'b0;
    tob_nxt = tob_c;
    str_nxt = str_c;
    esc_nxt = esc_c;

    if (tob_c) begin
      if (!str_c) begin
        nl = tok_td;
        if (tok_et) begin
          tob_nxt = 1'b0;
          nl      = 1'b1;
        end else if ((c == CH_LPAREN) && !esc_c) begin
          str_nxt = 1'b1;
          gap_sp  = exceed_raw & ~first;
        end
      end else begin
        if ((c == CH_RPAREN) && !esc_c) begin
          str_nxt = 1'b0;
        end else if ((c == CH_BSLASH) && !esc_c) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          txt     = is_print(c);
        end
      end
    end

    if (!tob_nxt && tok_bt) tob_nxt = 1'b1;

    // newline first, then the gap space or the text byte
    res.cnt = {1'b0, nl} + {1'b0, gap_sp | txt};
    res.b1  = gap_sp ? CH_SPACE : c;
    res.b0  = nl ? CH_LF : res.b1;

    for (int j = 0; j < W - 1; j++) begin
      win_nxt[j] = first ? CH_SPACE : win_r[j+1];
      dig_nxt[j] = first ? 1'b0 : dig_r[j+1];
      dot_nxt[j] = first ? 1'b0 : dot_r[j+1];
      sp_nxt[j]  = first ? 1'b1 : sp_r[j+1];
      nz_nxt[j]  = first ? 1'b1 : nz_r[j+1];
    end
    win_nxt[W-1] = c;
    dig_nxt[W-1] = is_dig(c);
    dot_nxt[W-1] = (c == CH_DOT);
    sp_nxt[W-1]  = (c == CH_SPACE);
    nz_nxt[W-1]  = (c != CH_ZERO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= {W{CH_SPACE}};
      dig_r <= '0;
      dot_r <= '0;
      sp_r  <= '1;
      nz_r  <= '1;
      tob_r <= 1'b0;
      str_r <= 1'b0;
      esc_r <= 1'b0;
    end else if (adv) begin
      win_r <= win_nxt;
      dig_r <= dig_nxt;
      dot_r <= dot_nxt;
      sp_r  <= sp_nxt;
      nz_r  <= nz_nxt;
      tob_r <= tob_nxt;
      str_r <= str_nxt;
      esc_r <= esc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pdf_content_text_extractor.sv
// PDF content-stream text extractor.
// in_ch  : content-stream bytes (in_byte, first_of_stream); a transaction is
//          taken when valid and ready are both high. first_of_stream clears
//          the window and flags before its byte is looked at.
// out_ch : extracted text bytes (out_byte, last). last marks the final result
//          of one input byte; a byte may give zero, one or two results.
// APB    : one register, gap_threshold at byte address 0 (bits 15:0). Writes
//          complete in the access cycle, pready is tied high, reads return
//          the register. Write it only while no transaction is in flight.
// Path   : a taken byte waits in the input register, then moves into the
//          result register, from which out_ch shows its first result.
// Throughput: one byte per cycle for bytes with zero or one result, while
//          out_ch.ready is high. A byte with two results (newline then space)
//          holds the next byte back until the result register drains its first.
// Stall: when out_ch.ready is low the result register holds, the input
//          register fills and in_ch.ready drops; nothing is dropped.
// Reset (rst_n low, synchronous): window filled with spaces, flags cleared,
//          both registers emptied, gap_threshold back to 100.
`default_nettype none

module pdf_content_text_extractor #(
  parameter int unsigned WINDOW_BYTES = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pdfx_in_if.sink                     in_ch,
  pdfx_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdfx_pkg::ADDR_W-1:0] paddr,
  input  logic [pdfx_pkg::DATA_W-1:0] pwdata,
  output logic [pdfx_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import pdfx_pkg::*;

  // input register
  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_item_r, in_item_nxt;
  logic      in_take, proc, res_free;

  // gap threshold register
  logic [GAP_W-1:0] gap_r, gap_nxt;
  logic [0:0]       reg_idx;
  logic             cfg_wr;

  res_pair_t res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    gap_nxt = gap_r;
    prdata  = '0;
    unique case (reg_idx)
      REG_GAP_THRESHOLD: begin
        prdata = DATA_W'(gap_r);
        if (cfg_wr) gap_nxt = pwdata[GAP_W-1:0];
      end
      default: ;  // outside the register map: ignored, reads zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
    end else begin
      gap_r <= gap_nxt;
    end
  end

  // the held byte moves on once the result register can take its results
  assign proc        = in_vld_r && res_free;
  assign in_ch.ready = !in_vld_r || proc;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_item_nxt = in_item_r;
    if (proc) in_vld_nxt = 1'b0;
    if (in_take) begin
      in_vld_nxt                  = 1'b1;
      in_item_nxt.in_byte         = in_ch.in_byte;
      in_item_nxt.first_of_stream = in_ch.first_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
  end

  // token detection, string tracking, number compare
  pdfx_parse #(.WINDOW_BYTES(WINDOW_BYTES)) u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (proc),
    .item          (in_item_r),
    .gap_threshold (gap_r),
    .res           (res)
  );

  // result register, drained one byte per cycle while out_ch.ready is high
  pdfx_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last),
    .free      (res_free)
  );

endmodule

`default_nettype wire

>>> rtl/pdfx_checker.sv
`default_nettype none

module pdfx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import pdfx_pkg::*;

  // result register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

  // a non-final result is always followed at once by the final one
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("second result of a pair missing");

  // only a newline ever leads a pair
  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_byte == CH_LF)
    else $error("non-final result is not a newline");

endmodule

bind pdf_content_text_extractor pdfx_checker u_pdfx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

// Testbench for pdf_content_text_extractor.
// Content-stream bytes go in on in_bus; the extracted text comes back on
// out_bus. A predictor runs beside the block. It keeps its own
// history window, flags and gap threshold, and queues the text it expects
// for each input transaction. A checker compares each output transaction
// against the oldest queued entry. The threshold register is only touched
// through the APB port, and only while the block is idle.
module tb;
  import pdfx_pkg::*;

  localparam int WIN = 15;
  localparam int unsigned INT_CAP = 32'h1FFFF;  // integer part saturates here
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;             // two pipeline stages plus slack

  localparam logic [ADDR_W-1:0] GAP_ADDR    = {REG_GAP_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = 3'd4;  // register index 1: none

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pdfx_in_if  in_bus ();
  pdfx_out_if out_bus ();

  pdf_content_text_extractor #(
    .WINDOW_BYTES(WIN)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------
  logic [7:0]  hist [WIN];
  logic        in_tobj;
  logic        in_str;
  logic        esc_pend;
  logic [15:0] gap_thr;

  text_beat_t  text_q [$];      // text still owed by the block
  in_item_t    stream_q [$];    // bytes waiting to be sent

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int idle_pct = 0;             // sender: chance per cycle of holding valid low
  int stall_pct = 0;            // receiver: chance per cycle of holding ready low
  int holdoff_left = 0;         // receiver: forced stall, counted down per cycle

  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // 32..126 and 128..254 show up in the text; everything else is dropped
  function automatic logic is_shown(input logic [7:0] b);
    return (b >= CH_SPACE && b <= CH_TILDE) || (b >= CH_HIGH && b < CH_FF);
  endfunction

  // two-letter operator bounded by separators at the newest end of the window
  function automatic logic op_at_tail(input logic [7:0] x, input logic [7:0] y);
    return hist[WIN-3] == x && hist[WIN-2] == y &&
           is_blank(hist[WIN-1]) && is_blank(hist[WIN-4]);
  endfunction

  function automatic void clear_window();
    for (int j = 0; j < WIN; j++) hist[j] = CH_SPACE;
    in_tobj  = 1'b0;
    in_str   = 1'b0;
    esc_pend = 1'b0;
  endfunction

  // Decimal number just before '(' versus the threshold, compared exactly.
  // Trailing spaces are skipped; the oldest window byte never joins the run.
  function automatic logic number_over_gap();
    int          k;
    int          s;
    int          p;
    int unsigned ival;
    int          ndig;
    logic        frac_nz;
    k = WIN - 1;
    while (k > 0 && hist[k] == CH_SPACE) k--;
    s = k;
    while (s > 0 && (is_numeral(hist[s]) || hist[s] == CH_DOT)) s--;
    p = s + 1;
    ival = 0;
    ndig = 0;
    frac_nz = 1'b0;
    while (p <= k && is_numeral(hist[p])) begin
      ival = ival * 10 + int'(hist[p] - CH_ZERO);
      if (ival > INT_CAP) ival = INT_CAP;
      ndig++;
      p++;
    end
    if (p <= k && hist[p] == CH_DOT) begin
      p++;
      while (p <= k && is_numeral(hist[p])) begin
        if (hist[p] != CH_ZERO) frac_nz = 1'b1;
        ndig++;
        p++;
      end
    end
    if (ndig == 0) return 1'b0;
    return ival > gap_thr || (ival == gap_thr && frac_nz);
  endfunction

  // One content-stream byte through the predictor; queues 0..2 text beats.
  function automatic void predict_text(input logic [7:0] c, input logic first);
    logic [7:0] res [2];
    int         n;
    text_beat_t beat;
    n = 0;
    if (first) clear_window();
    if (in_tobj) begin
      if (!in_str) begin
        // operators are looked at before the new byte shifts in
        if (op_at_tail(CH_T, CH_UD) || op_at_tail(CH_T, CH_LD)) begin
          res[n] = CH_LF;
          n++;
        end
        if (op_at_tail(CH_E, CH_T)) begin
          in_tobj = 1'b0;
          res[n] = CH_LF;
          n++;
        end else if (c == CH_LPAREN && !esc_pend) begin
          in_str = 1'b1;
          if (number_over_gap()) begin
            res[n] = CH_SPACE;
            n++;
          end
        end
      end else begin
        if (c == CH_RPAREN && !esc_pend) begin
          in_str = 1'b0;
        end else if (c == CH_BSLASH && !esc_pend) begin
          esc_pend = 1'b1;
        end else begin
          esc_pend = 1'b0;
          if (is_shown(c)) begin
            res[n] = c;
            n++;
          end
        end
      end
    end
    for (int j = 0; j < WIN - 1; j++) hist[j] = hist[j+1];
    hist[WIN-1] = c;
    // BT is looked at after the shift
    if (!in_tobj && op_at_tail(CH_B, CH_T)) in_tobj = 1'b1;
    for (int j = 0; j < n; j++) begin
      beat.text = res[j];
      beat.last = (j == n - 1);
      text_q.push_back(beat);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    text_beat_t want;
    if (!rst_n) begin
      clear_window();
      gap_thr = GAP_RESET;
      text_q.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (text_q.size() == 0) begin
          $error("unexpected output transaction: out_byte=%h last=%b",
                 out_bus.out_byte, out_bus.last);
          fail_cnt++;
        end else begin
          want = text_q.pop_front();
          if (out_bus.out_byte !== want.text) begin
            $error("out_byte mismatch: expected %h, got %h", want.text, out_bus.out_byte);
            fail_cnt++;
          end
          if (out_bus.last !== want.last) begin
            $error("last mismatch: expected %b, got %b", want.last, out_bus.last);
            fail_cnt++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready)
        predict_text(in_bus.in_byte, in_bus.first_of_stream);
      // register write lands at the access cycle; other addresses are ignored
      if (psel && penable && pwrite && pready && paddr == GAP_ADDR)
        gap_thr = pwdata[15:0];
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: a forced hold-off wins over the random stall
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_bus.ready = 1'b0;
    end else begin
      out_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Drivers: inputs change at the falling edge
  // ---------------------------------------------------------------------
  task automatic send_byte(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.in_byte = it.in_byte;
    in_bus.first_of_stream = it.first_of_stream;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_queued();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  // all owed text back, then room for bytes that give no text to clear out
  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (text_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_check_read(input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b0;
    penable = 1'b0;
    paddr = addr;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0000, gap_thr}) begin
      $error("prdata mismatch: expected %h, got %h", {16'h0000, gap_thr}, prdata);
      fail_cnt++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Content-stream builders
  // ---------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    in_item_t it;
    it.in_byte = b;
    it.first_of_stream = 1'b0;
    stream_q.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_sep();
    int r;
    r = $urandom_range(9);
    if (r < 7) push_byte(CH_SPACE);
    else if (r == 7) push_byte(CH_CR);
    else if (r == 8) push_byte(CH_LF);
    else push_text("  ");
  endfunction

  // what sits between a number and '(' - none, spaces or a line break
  function automatic void push_paren_gap();
    case ($urandom_range(4))
      0, 1:    ;
      2:       push_byte(CH_SPACE);
      3:       push_text("   ");
      default: push_byte(CH_LF);
    endcase
  endfunction

  function automatic void push_number();
    string s;
    int    v;
    int    nd;
    case ($urandom_range(9))
      0, 1, 2: begin
        // right around the threshold, often with a fraction
        v = int'(gap_thr) + int'($urandom_range(4)) - 2;
        if (v < 0) v = 0;
        s = $sformatf("%0d", v);
        case ($urandom_range(5))
          0: s = {s, ".0"};
          1: s = {s, ".00"};
          2: s = {s, ".5"};
          3: s = {s, ".05"};
          4: s = {s, "."};
          default: ;
        endcase
      end
      3, 4: s = $sformatf("%0d", $urandom_range(999));
      5:    s = $sformatf("%0d", $urandom_range(99999));
      6: begin
        // long runs: saturation, and runs wider than the window
        nd = $urandom_range(6, 20);
        s = "";
        for (int i = 0; i < nd; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
      end
      7: begin
        case ($urandom_range(5))
          0: s = ".";
          1: s = "..";
          2: s = "1.2.3";
          3: s = ".5";
          4: s = "-250";
          default: s = "0.0";
        endcase
      end
      8: s = $sformatf("%0d.%0d", gap_thr, $urandom_range(99));
      default: s = $sformatf("%07d", gap_thr);
    endcase
    push_text(s);
  endfunction

  // string contents: plain text, escapes, high bytes, control bytes, fake operators
  function automatic void push_body();
    int         n;
    int         r;
    logic [7:0] b;
    n = $urandom_range(8);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 60) begin
        b = 8'($urandom_range(32, 126));
        if (b == CH_RPAREN || b == CH_BSLASH) b = CH_E;
        push_byte(b);
      end else if (r < 70) begin
        push_byte(CH_BSLASH);
        push_byte(8'($urandom_range(255)));
      end else if (r < 80) begin
        push_byte(8'($urandom_range(128, 255)));
      end else if (r < 88) begin
        if ($urandom_range(1)) push_byte(8'($urandom_range(31)));
        else push_byte(8'h7f);
      end else begin
        case ($urandom_range(3))
          0: push_text("ET");
          1: push_text(" ET ");
          2: push_text(" Td ");
          default: push_text(" BT ");
        endcase
      end
    end
  endfunction

  function automatic void push_text_op();
    case ($urandom_range(4))
      0: begin
        push_number(); push_sep(); push_number(); push_sep();
        push_text($urandom_range(1) ? "Td" : "TD"); push_sep();
      end
      1: begin
        push_number(); push_paren_gap(); push_byte(CH_LPAREN); push_body();
        if ($urandom_range(9) != 0) push_byte(CH_RPAREN);   // sometimes left open
        push_sep(); push_text("Tj"); push_sep();
      end
      2: begin
        push_text("[("); push_body(); push_byte(CH_RPAREN);
        push_number(); push_paren_gap(); push_byte(CH_LPAREN); push_body();
        push_text(")]"); push_sep(); push_text("TJ"); push_sep();
      end
      3: begin
        // Td with a string right behind it
        push_number(); push_sep(); push_number(); push_sep();
        push_text($urandom_range(1) ? "Td" : "TD"); push_sep();
        push_byte(CH_LPAREN); push_body(); push_byte(CH_RPAREN);
        push_sep(); push_text("Tj"); push_sep();
      end
      default: begin
        push_text("/F1 12 Tf"); push_sep();
      end
    endcase
  endfunction

  // One piece of stream: mostly well-formed text objects, some raw noise,
  // some text objects cut short.
  function automatic void build_stream();
    int n;
    if ($urandom_range(99) < 85) begin
      push_sep();
      if ($urandom_range(19) == 0) push_byte(8'($urandom_range(33, 126)));  // glued BT
      push_text("BT");
      push_sep();
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) push_text_op();
      push_text("ET");
      push_sep();
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) if (stream_q.size() > 1) void'(stream_q.pop_back());
      end
      if ($urandom_range(99) < 40) stream_q[0].first_of_stream = 1'b1;
    end else begin
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        push_byte(8'($urandom_range(255)));
        if ($urandom_range(19) == 0) stream_q[stream_q.size()-1].first_of_stream = 1'b1;
      end
    end
  endfunction

  task automatic run_streams(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_stream();
      sent += stream_q.size();
      send_queued();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // reset value, read back, and a write to an address with no register
  task automatic test_register_access();
    apb_check_read(GAP_ADDR);
    apb_write(UNUSED_ADDR, 32'h0000_1234);
    apb_check_read(GAP_ADDR);
    apb_write(GAP_ADDR, 32'hA5A5_0000 | 32'(GAP_RESET));
    apb_check_read(GAP_ADDR);
  endtask

  // hand-built stream: escapes, dropped bytes, exact number compare,
  // CR as a separator, Td then a string, ET
  task automatic test_directed();
    push_text(" BT");
    push_byte(CH_CR);
    push_text("101(");           // above 100: leading space
    push_byte(CH_BSLASH);
    push_byte(CH_RPAREN);        // escaped close paren is text
    push_byte(8'h00);
    push_byte(8'h7f);
    push_byte(8'hfe);
    push_byte(CH_FF);
    push_byte(CH_HIGH);
    push_text("~) 100(");        // equal: no space
    push_text(") 100.5(");       // equal integer, nonzero fraction: space
    push_text(") Td (A) ET");
    push_byte(CH_LF);
    stream_q[0].first_of_stream = 1'b1;
    send_queued();
  endtask

  task automatic test_phase(input logic [15:0] thr, input int snd_idle, input int rcv_stall,
                            input int n_bytes);
    wait_idle();
    apb_write(GAP_ADDR, {16'($urandom), thr});
    @(posedge clk);
    idle_pct = snd_idle;
    stall_pct = rcv_stall;
    run_streams(n_bytes);
  endtask

  // receiver blocks for a long stretch while the sender keeps pushing text
  task automatic test_input_stall();
    wait_idle();
    @(posedge clk);
    idle_pct = 0;
    stall_pct = 0;
    push_text(" BT (");
    repeat (60) push_byte(8'($urandom_range(65, 90)));
    push_text(") Tj ET ");
    holdoff_left = 150;
    send_queued();
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.in_byte = 8'h00;
    in_bus.first_of_stream = 1'b0;
    out_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_register_access();
    test_directed();
    test_phase(16'd0, 0, 0, 450);
    test_phase(16'hFFFF, 86, 0, 450);
    test_phase(16'($urandom_range(1, 999)), 0, 86, 450);
    test_phase(16'($urandom_range(0, 65535)), 22, 22, 450);
    test_input_stall();
    wait_idle();

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
